@@ sv/fmi_pkg.sv @@
package fmi_pkg;

    localparam int DATA_W   = 30;
    localparam int EXP_BITS = 30;

    typedef logic [DATA_W-1:0] t_word;

    localparam t_word       MODULUS    = 30'd1000000007;
    localparam logic [31:0] MODULUS_32 = 32'd1000000007;
    localparam logic [31:0] MODULUS_X2 = 32'd2000000014;
    // Fermat exponent: modulus minus two
    localparam t_word       EXPONENT   = 30'd1000000005;
    localparam t_word       ONE        = 30'd1;

    // Barrett constant floor(2^60 / p), fits in 31 bits
    localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    // register stages in one modular multiply
    localparam int MM_STAGES = 4;
    // input reduction stage plus one modular multiply per exponent bit
    localparam int LATENCY   = 1 + EXP_BITS * MM_STAGES;

endpackage

@@ sv/fmi_modmul.sv @@
module fmi_modmul (
    input  logic           i_clk,
    input  fmi_pkg::t_word i_a,
    input  fmi_pkg::t_word i_b,
    output fmi_pkg::t_word o_p
);
    import fmi_pkg::*;

    // stage 1: full product
    logic [59:0] r_prod;
    // stage 2: q1 * mu, low product bits carried along
    logic [61:0] r_qmu;
    logic [31:0] r_xlo2;
    // stage 3: low bits of q3 * p
    logic [31:0] r_qp;
    logic [31:0] r_xlo3;
    // stage 4: corrected remainder
    t_word       r_res;

    logic [61:0] n_qmu;
    logic [31:0] n_qp;
    logic [31:0] w_rem;
    logic [31:0] w_rem1;
    logic [31:0] w_rem2;
    t_word       n_res;

    always_comb begin
        n_qmu = {31'd0, r_prod[59:29]} * {31'd0, BARRETT_MU};
        // only the low 32 bits matter: the true remainder is below 3p < 2^32
        n_qp  = 32'(r_qmu[61:31]) * MODULUS_32;
    end

    always_comb begin
        w_rem  = r_xlo3 - r_qp;
        w_rem1 = w_rem - MODULUS_32;
        w_rem2 = w_rem - MODULUS_X2;
        if (w_rem >= MODULUS_X2) begin
            n_res = w_rem2[DATA_W-1:0];
        end else if (w_rem >= MODULUS_32) begin
            n_res = w_rem1[DATA_W-1:0];
        end else begin
            n_res = w_rem[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {30'd0, i_a} * {30'd0, i_b};
        r_qmu  <= n_qmu;
        r_xlo2 <= r_prod[31:0];
        r_qp   <= n_qp;
        r_xlo3 <= r_xlo2;
        r_res  <= n_res;
    end

    assign o_p = r_res;

endmodule

@@ sv/fmi_step.sv @@
module fmi_step #(
    parameter bit BIT_SET = 1'b1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fmi_pkg::t_word i_sq,
    input  fmi_pkg::t_word i_acc,
    output logic           o_valid,
    output fmi_pkg::t_word o_sq,
    output fmi_pkg::t_word o_acc
);
    import fmi_pkg::*;

    logic [MM_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MM_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[MM_STAGES-1];

    fmi_modmul u_square (
        .i_clk (i_clk),
        .i_a   (i_sq),
        .i_b   (i_sq),
        .o_p   (o_sq)
    );

    generate
        if (BIT_SET) begin : g_mul
            fmi_modmul u_acc (
                .i_clk (i_clk),
                .i_a   (i_acc),
                .i_b   (i_sq),
                .o_p   (o_acc)
            );
        end else begin : g_dly
            // accumulator just waits alongside the square
            t_word r_dly [MM_STAGES];
            always_ff @(posedge i_clk) begin
                r_dly[0] <= i_acc;
                for (int i = 1; i < MM_STAGES; i++) begin
                    r_dly[i] <= r_dly[i-1];
                end
            end
            assign o_acc = r_dly[MM_STAGES-1];
        end
    endgenerate

endmodule

@@ sv/fermat_modular_inverse_core.sv @@
// Channel   Handshake             Payload     Width
// input     start / busy          i_operand   30
// result    o_done (strobe)       o_inverse   30
//
// Each operand passes one reduction stage, then a 4-stage modular multiply
// (Barrett) for each of the 30 exponent bits, square and multiply side by side.
// One operand may be taken every cycle; busy is high only while in reset.
// Reset is synchronous, active low, and clears the valid bits in flight.
// Results are presented for one cycle with o_done; there is no back-pressure.
module fermat_modular_inverse_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  fmi_pkg::t_word i_operand,
    output logic           busy,
    output logic           o_done,
    output fmi_pkg::t_word o_inverse
);
    import fmi_pkg::*;

    logic                 r_vld0;
    t_word                r_base;
    t_word                n_base;
    logic [MM_STAGES-1:0] r_vld_out;

    t_word                w_sq  [EXP_BITS];
    t_word                w_acc [EXP_BITS];
    logic [EXP_BITS-1:0]  w_vld;

    assign busy = ~i_rst_n;

    // operands up to 2^30-1 are below 2p, so one subtract reduces them
    assign n_base = (i_operand >= MODULUS) ? (i_operand - MODULUS) : i_operand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
    end

    assign w_sq[0]  = r_base;
    assign w_acc[0] = ONE;
    assign w_vld[0] = r_vld0;

    generate
        for (genvar k = 0; k < EXP_BITS - 1; k++) begin : g_step
            fmi_step #(
                .BIT_SET (EXPONENT[k])
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_vld[k]),
                .i_sq    (w_sq[k]),
                .i_acc   (w_acc[k]),
                .o_valid (w_vld[k+1]),
                .o_sq    (w_sq[k+1]),
                .o_acc   (w_acc[k+1])
            );
        end
    endgenerate

    // top exponent bit is set and its square is never needed
    fmi_modmul u_last (
        .i_clk (i_clk),
        .i_a   (w_acc[EXP_BITS-1]),
        .i_b   (w_sq[EXP_BITS-1]),
        .o_p   (o_inverse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= '0;
        end else begin
            r_vld_out <= {r_vld_out[MM_STAGES-2:0], w_vld[EXP_BITS-1]};
        end
    end

    assign o_done = r_vld_out[MM_STAGES-1];

endmodule

@@ sv/fmi_checker.sv @@
module fmi_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input fmi_pkg::t_word i_operand,
    input logic           busy,
    input logic           o_done,
    input fmi_pkg::t_word o_inverse
);
    import fmi_pkg::*;

    // every transfer comes out after the fixed latency
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result strobe missing after transfer");

    // no strobe without a matching transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_done)
        else $error("result strobe without transfer");

    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_inverse < MODULUS))
        else $error("result not reduced");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operand == '0) |-> ##LATENCY (o_inverse == '0))
        else $error("zero operand gave non-zero result");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operand == ONE) |-> ##LATENCY (o_inverse == ONE))
        else $error("inverse of one is not one");

endmodule

bind fermat_modular_inverse_core fmi_checker u_fmi_checker (.*);

@@ sim/tb_fermat_modular_inverse_core.sv @@
module tb_fermat_modular_inverse_core;

    import fmi_pkg::*;

    localparam int      RANDOM_ITEMS   = 450;
    localparam int      IDLE_LIMIT     = 2000;
    localparam t_word   ALL_ONES       = {DATA_W{1'b1}};
    localparam t_word   HALF_INVERSE   = 30'd500000004;  // inverse of two
    localparam t_word   ALT_ONES       = 30'h2AAAAAAA;
    localparam t_word   ALT_ZEROS      = 30'h15555555;

    class inverse_scoreboard;
        t_word expected_inverses[$];
        int    failures = 0;
        int    matched  = 0;

        // square-and-multiply over the exponent bits, lsb first
        function t_word predict_inverse(t_word operand);
            logic [63:0] acc;
            logic [63:0] sq;
            acc = 64'd1;
            sq  = {34'd0, operand} % {34'd0, MODULUS};
            for (int b = 0; b < EXP_BITS; b++) begin
                if (EXPONENT[b])
                    acc = (acc * sq) % {34'd0, MODULUS};
                sq = (sq * sq) % {34'd0, MODULUS};
            end
            return acc[DATA_W-1:0];
        endfunction

        function void note_operand(t_word operand);
            expected_inverses.insert(expected_inverses.size(), predict_inverse(operand));
        endfunction

        function void check_inverse(t_word got);
            t_word want;
            if (expected_inverses.size() == 0) begin
                $error("inverse: expected none, got %0d", got);
                failures++;
            end else begin
                want = expected_inverses.pop_front();
                if (want !== got) begin
                    $error("inverse: expected %0d, got %0d", want, got);
                    failures++;
                end else begin
                    matched++;
                end
            end
        endfunction

        function int pending();
            return expected_inverses.size();
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_word i_operand = '0;
    logic  busy;
    logic  o_done;
    t_word o_inverse;

    inverse_scoreboard sb;
    int taken = 0;
    int sent = 0;
    int idle_cycles = 0;
    int above_modulus = 0;
    int drains = 0;

    fermat_modular_inverse_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_operand (i_operand),
        .busy      (busy),
        .o_done    (o_done),
        .o_inverse (o_inverse)
    );

    always #5 i_clk = ~i_clk;

    // transfers and results are sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_operand(i_operand);
                taken++;
            end
            if (o_done)
                sb.check_inverse(o_inverse);
            if ((start && !busy) || o_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("watchdog: %0d cycles without a transfer or result", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_operand(input t_word value, input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_operand = value;
        sent++;
        if (value >= MODULUS)
            above_modulus++;
        do @(negedge i_clk); while (taken < sent);
    endtask

    task automatic drain_inverses();
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
        drains++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 150);
    endfunction

    function automatic t_word pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return t_word'($urandom_range(0, MODULUS_32 - 1));
        else if (roll < 88)
            return t_word'($urandom_range(MODULUS_32, 32'(ALL_ONES)));
        else if (roll < 94)
            return t_word'($urandom_range(0, 4));
        else
            return MODULUS - t_word'($urandom_range(1, 3));
    endfunction

    initial begin
        t_word directed[$];
        int burst;

        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = '{30'd0, ONE, 30'd2, 30'd3, HALF_INVERSE, MODULUS - ONE,
                     MODULUS - 30'd2, MODULUS, MODULUS + ONE, MODULUS + 30'd2,
                     ALL_ONES, ALL_ONES - ONE, ALT_ONES, ALT_ZEROS,
                     30'h20000000, 30'h1FFFFFFF, 30'd12345, 30'd0};
        foreach (directed[k])
            send_operand(directed[k], (k % 3 == 2) ? k : 0);
        drain_inverses();

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // occasional back-to-back stretches with no idling
            if (burst == 0 && $urandom_range(0, 19) == 0)
                burst = $urandom_range(10, 40);
            if (burst > 0) begin
                send_operand(pick_operand(), 0);
                burst--;
            end else begin
                send_operand(pick_operand(), pick_gap());
            end
            if (n == RANDOM_ITEMS / 2)
                drain_inverses();
        end
        start = 1'b0;

        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("inverse: %0d results never arrived", sb.pending());
            sb.failures++;
        end

        $display("%0d operands sent (%0d at or above the modulus), %0d inverses matched",
                 sent, above_modulus, sb.matched);
        $display("sender drained the pipeline %0d times mid-run", drains);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
